// ===== rtl/i2csmq_pkg.sv =====
// shared types and constants for the i2c slave message queue
package i2csmq_pkg;

  localparam int unsigned CounterWidth = 16;
  localparam int unsigned FillWidth    = 10;
  localparam int unsigned LengthWidth  = 7;

  localparam logic [2:0] CMD_ADDR_MATCH = 3'd0;
  localparam logic [2:0] CMD_RX_BYTE    = 3'd1;
  localparam logic [2:0] CMD_STOP       = 3'd2;
  localparam logic [2:0] CMD_BUS_ERROR  = 3'd3;
  localparam logic [2:0] CMD_POP        = 3'd4;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_BYTE  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    OP_MATCH,
    OP_BYTE,
    OP_STOP,
    OP_ERROR,
    OP_POP,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [7:0]              msg_byte;
    logic [LengthWidth-1:0]  msg_length;
    logic                    last;
    logic [CounterWidth-1:0] address_matches;
    logic [CounterWidth-1:0] messages_queued;
    logic [CounterWidth-1:0] overflows;
    logic [CounterWidth-1:0] bytes_seen;
    logic [FillWidth-1:0]    queue_fill;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } op_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_FINISH,
    ST_POP_LEN,
    ST_POP_RD,
    ST_POP_OUT
  } state_e;

endpackage

// ===== rtl/i2csmq_front.sv =====
// input side: decodes items and holds them in a two entry queue
module i2csmq_front import i2csmq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  output logic     op_valid_o,
  input  logic     op_ready_i,
  output op_item_t op_o
);

  op_item_t   slot_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  op_item_t   dec;
  logic       wr, rd;

  always_comb begin
    dec.data = in_item_i.rx_byte;
    unique case (in_item_i.command)
      CMD_ADDR_MATCH: dec.op = OP_MATCH;
      CMD_RX_BYTE:    dec.op = OP_BYTE;
      CMD_STOP:       dec.op = OP_STOP;
      CMD_BUS_ERROR:  dec.op = OP_ERROR;
      CMD_POP:        dec.op = OP_POP;
      default:        dec.op = OP_NOP;
    endcase
  end

  assign full       = (cnt_q == 2'd2);
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = slot_q[rp_q];
  assign wr         = push && !full;
  assign rd         = op_valid_o && op_ready_i;

  always_comb begin
    wp_d  = wr ? !wp_q : wp_q;
    rp_d  = rd ? !rp_q : rp_q;
    cnt_d = cnt_q + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      slot_q[wp_q] <= dec;
    end
  end

endmodule

// ===== rtl/i2csmq_back.sv =====
// execution side: message buffer, byte queue, counters and result register
module i2csmq_back import i2csmq_pkg::*; #(
  parameter int unsigned MSG_BUF_BYTES = 64,
  parameter int unsigned QUEUE_BYTES   = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  output logic      op_ready_o,
  input  op_item_t  op_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  localparam int unsigned FW  = $clog2(MSG_BUF_BYTES + 1);
  localparam int unsigned BIW = (MSG_BUF_BYTES > 1) ? $clog2(MSG_BUF_BYTES) : 1;
  localparam int unsigned PW  = $clog2(QUEUE_BYTES);
  localparam int unsigned CW  = $clog2(QUEUE_BYTES + 1);
  localparam int unsigned SW  = CW + 9;

  logic [7:0] buf_mem [MSG_BUF_BYTES];
  logic [7:0] q_mem [QUEUE_BYTES];
  logic [7:0] buf_rdata_q, q_rdata_q;

  state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d, ridx_q, ridx_d;
  logic pend_q, pend_d;
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0] len_q, len_d, rem_q, rem_d;
  logic [CounterWidth-1:0] mat_q, mat_d, msg_q, msg_d, ovf_q, ovf_d, byt_q, byt_d;
  logic ovalid_q, ovalid_d;
  out_item_t oitem_q, oitem_d;

  logic out_free, emit;
  logic [1:0] e_status;
  logic [7:0] e_byte;
  logic e_last, e_len;
  logic buf_we, buf_re, q_we, q_re;
  logic [7:0] q_wdata;
  logic [SW-1:0] need;

  assign out_free   = !ovalid_q || pop;
  assign empty      = !ovalid_q;
  assign out_item_o = oitem_q;
  assign op_ready_o = (state_q == ST_IDLE) && out_free;
  assign need       = SW'(count_q) + SW'(fill_q) + SW'(1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_BYTES - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    ridx_d   = ridx_q;
    pend_d   = 1'b0;
    wp_d     = wp_q;
    rp_d     = rp_q;
    count_d  = count_q;
    len_d    = len_q;
    rem_d    = rem_q;
    mat_d    = mat_q;
    msg_d    = msg_q;
    ovf_d    = ovf_q;
    byt_d    = byt_q;
    emit     = 1'b0;
    e_status = STATUS_DONE;
    e_byte   = 8'd0;
    e_last   = 1'b1;
    e_len    = 1'b0;
    buf_we   = 1'b0;
    buf_re   = 1'b0;
    q_we     = 1'b0;
    q_re     = 1'b0;
    q_wdata  = buf_rdata_q;
    unique case (state_q)
      ST_IDLE: begin
        if (op_valid_i && out_free) begin
          unique case (op_i.op)
            OP_MATCH: begin
              fill_d = '0;
              mat_d  = mat_q + 1'b1;
              emit   = 1'b1;
            end
            OP_BYTE: begin
              byt_d = byt_q + 1'b1;
              if (fill_q >= FW'(MSG_BUF_BYTES)) begin
                ovf_d = ovf_q + 1'b1;
              end else begin
                buf_we = 1'b1;
                fill_d = fill_q + FW'(1);
              end
              emit = 1'b1;
            end
            OP_STOP: begin
              if (fill_q == '0) begin
                emit = 1'b1;
              end else if (need > SW'(QUEUE_BYTES)) begin
                ovf_d = ovf_q + 1'b1;
                emit  = 1'b1;
              end else begin
                q_we    = 1'b1;
                q_wdata = 8'(fill_q);
                wp_d    = ptr_inc(wp_q);
                count_d = count_q + CW'(1);
                ridx_d  = '0;
                state_d = ST_COPY;
              end
            end
            OP_ERROR: begin
              fill_d = '0;
              emit   = 1'b1;
            end
            OP_POP: begin
              if (count_q == '0) begin
                e_status = STATUS_EMPTY;
                emit     = 1'b1;
              end else begin
                q_re    = 1'b1;
                rp_d    = ptr_inc(rp_q);
                state_d = ST_POP_LEN;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      ST_COPY: begin
        if (ridx_q < fill_q) begin
          buf_re = 1'b1;
          ridx_d = ridx_q + FW'(1);
          pend_d = 1'b1;
        end
        if (pend_q) begin
          q_we    = 1'b1;
          wp_d    = ptr_inc(wp_q);
          count_d = count_q + CW'(1);
        end
        if (!(ridx_q < fill_q) && !pend_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          fill_d  = '0;
          msg_d   = msg_q + 1'b1;
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_POP_LEN: begin
        len_d   = q_rdata_q;
        rem_d   = q_rdata_q;
        count_d = CW'(SW'(count_q) - SW'(1) - SW'(q_rdata_q));
        state_d = ST_POP_RD;
      end
      ST_POP_RD: begin
        q_re    = 1'b1;
        rp_d    = ptr_inc(rp_q);
        rem_d   = rem_q - 8'd1;
        state_d = ST_POP_OUT;
      end
      ST_POP_OUT: begin
        if (out_free) begin
          emit     = 1'b1;
          e_status = STATUS_BYTE;
          e_byte   = q_rdata_q;
          e_len    = 1'b1;
          e_last   = (rem_q == 8'd0);
          state_d  = (rem_q == 8'd0) ? ST_IDLE : ST_POP_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    oitem_d                 = oitem_q;
    oitem_d.status          = e_status;
    oitem_d.msg_byte        = e_byte;
    oitem_d.msg_length      = e_len ? LengthWidth'(len_q) : '0;
    oitem_d.last            = e_last;
    oitem_d.address_matches = mat_d;
    oitem_d.messages_queued = msg_d;
    oitem_d.overflows       = ovf_d;
    oitem_d.bytes_seen      = byt_d;
    oitem_d.queue_fill      = FillWidth'(count_d);
    ovalid_d = emit ? 1'b1 : (pop ? 1'b0 : ovalid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      ridx_q   <= '0;
      pend_q   <= 1'b0;
      wp_q     <= '0;
      rp_q     <= '0;
      count_q  <= '0;
      mat_q    <= '0;
      msg_q    <= '0;
      ovf_q    <= '0;
      byt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      ridx_q   <= ridx_d;
      pend_q   <= pend_d;
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      count_q  <= count_d;
      mat_q    <= mat_d;
      msg_q    <= msg_d;
      ovf_q    <= ovf_d;
      byt_q    <= byt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    rem_q <= rem_d;
    if (emit) begin
      oitem_q <= oitem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[fill_q[BIW-1:0]] <= op_i.data;
    end
    if (buf_re) begin
      buf_rdata_q <= buf_mem[ridx_q[BIW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[wp_q] <= q_wdata;
    end
    if (q_re) begin
      q_rdata_q <= q_mem[rp_q];
    end
  end

endmodule

// ===== rtl/i2c_slave_message_queue_core.sv =====
// top level of the i2c slave message queue
//
// items enter through push/full: an item is taken on a clock edge with push
// high and full low. a two entry queue of decoded items sits in front of the
// execution side, so up to two items can be taken while it is busy.
// results leave through empty/pop: the oldest result is on out_item_o while
// empty is low and is taken on an edge with pop high.
// address match, byte, bus error, unknown commands and a stop that queues
// nothing each give one result, written to the result register when the
// execution side takes them. a stop that queues a message of n bytes writes
// the length byte, copies the buffer through its registered read port and
// then gives one result. a pop of an n byte message reads the length byte
// and then gives n results, each through the queue memory's registered read.
// when pop stays low the result register holds and the execution side waits;
// the front queue then fills and full rises.
// reset empties both queues and clears the counters, buffer fill and queue
// pointers; memory contents are left as they are.
module i2c_slave_message_queue_core import i2csmq_pkg::*; #(
  parameter int unsigned MSG_BUF_BYTES = 64,
  parameter int unsigned QUEUE_BYTES   = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic     op_valid, op_ready;
  op_item_t op_item;

  i2csmq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op_item)
  );

  i2csmq_back #(
    .MSG_BUF_BYTES (MSG_BUF_BYTES),
    .QUEUE_BYTES   (QUEUE_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_ready_o (op_ready),
    .op_i       (op_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

// ===== verif/i2c_slave_message_queue_core_tb.sv =====
// testbench for the i2c slave message queue core: predicted results checked in order
`timescale 1ns / 100ps

module i2c_slave_message_queue_core_tb;
  import i2csmq_pkg::*;

  localparam int unsigned BufBytes   = 64;
  localparam int unsigned QueueBytes = 512;
  localparam int unsigned CycleLimit = 900000;

  logic      clk;
  logic      rst_n;
  logic      push_q;
  logic      full_w;
  in_item_t  in_q;
  logic      empty_w;
  logic      pop_q;
  out_item_t out_w;

  i2c_slave_message_queue_core #(
    .MSG_BUF_BYTES(BufBytes),
    .QUEUE_BYTES  (QueueBytes)
  ) u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .push      (push_q),
    .full      (full_w),
    .in_item_i (in_q),
    .empty     (empty_w),
    .pop       (pop_q),
    .out_item_o(out_w)
  );

  // predictor state
  logic [7:0]              msg_buf [BufBytes];
  int unsigned             msg_fill;
  logic [7:0]              byte_queue [$];
  logic [CounterWidth-1:0] n_match, n_msg, n_ovf, n_bytes;

  out_item_t expected_results [$];
  int        errors;
  int        cycles;
  bit        rx_idle_on;
  bit        rx_hold;
  int        rx_idle_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic out_item_t make_result(logic [1:0] st, logic [7:0] b,
                                            logic [LengthWidth-1:0] len, logic lst);
    out_item_t r;
    r.status          = st;
    r.msg_byte        = b;
    r.msg_length      = len;
    r.last            = lst;
    r.address_matches = n_match;
    r.messages_queued = n_msg;
    r.overflows       = n_ovf;
    r.bytes_seen      = n_bytes;
    r.queue_fill      = FillWidth'(byte_queue.size());
    return r;
  endfunction

  task automatic predict_item(input in_item_t it);
    int unsigned len;
    logic [7:0]  taken [$];
    case (it.command)
      CMD_ADDR_MATCH: begin
        msg_fill = 0;
        n_match++;
        expected_results.push_back(make_result(STATUS_DONE, 8'd0, '0, 1'b1));
      end
      CMD_RX_BYTE: begin
        n_bytes++;
        if (msg_fill >= BufBytes) n_ovf++;
        else begin
          msg_buf[msg_fill] = it.rx_byte;
          msg_fill++;
        end
        expected_results.push_back(make_result(STATUS_DONE, 8'd0, '0, 1'b1));
      end
      CMD_STOP: begin
        if (msg_fill > 0) begin
          if (QueueBytes - byte_queue.size() >= msg_fill + 1) begin
            byte_queue.push_back(8'(msg_fill));
            for (int i = 0; i < msg_fill; i++) byte_queue.push_back(msg_buf[i]);
            msg_fill = 0;
            n_msg++;
          end else n_ovf++;
        end
        expected_results.push_back(make_result(STATUS_DONE, 8'd0, '0, 1'b1));
      end
      CMD_POP: begin
        if (byte_queue.size() == 0) begin
          expected_results.push_back(make_result(STATUS_EMPTY, 8'd0, '0, 1'b1));
        end else begin
          len = byte_queue.pop_front();
          for (int i = 0; i < len; i++) taken.push_back(byte_queue.pop_front());
          // every result of a pop carries the fill after the whole message is gone
          for (int i = 0; i < len; i++) begin
            expected_results.push_back(make_result(STATUS_BYTE, taken[i], LengthWidth'(len),
                                                   i + 1 == len));
          end
        end
      end
      CMD_BUS_ERROR: begin
        msg_fill = 0;
        expected_results.push_back(make_result(STATUS_DONE, 8'd0, '0, 1'b1));
      end
      default: expected_results.push_back(make_result(STATUS_DONE, 8'd0, '0, 1'b1));
    endcase
  endtask

  bit tx_idle_on;

  task automatic send_item(input logic [2:0] cmd, input logic [7:0] data);
    in_item_t it;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      push_q <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    it.command = cmd;
    it.rx_byte = data;
    push_q <= 1'b1;
    in_q   <= it;
    @(posedge clk);
    while (full_w) @(posedge clk);
    predict_item(it);
  endtask

  // result side: random pop stalls in bursts, and a long hold when requested
  always @(posedge clk) begin
    if (!rst_n) pop_q <= 1'b0;
    else begin
      if (pop_q && !empty_w) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", 32'(out_w.status), '0);
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (out_w.status != e.status) report("status", out_w.status, e.status);
          if (out_w.msg_byte != e.msg_byte) report("msg_byte", out_w.msg_byte, e.msg_byte);
          if (out_w.msg_length != e.msg_length)
            report("msg_length", out_w.msg_length, e.msg_length);
          if (out_w.last != e.last) report("last", out_w.last, e.last);
          if (out_w.address_matches != e.address_matches)
            report("address_matches", out_w.address_matches, e.address_matches);
          if (out_w.messages_queued != e.messages_queued)
            report("messages_queued", out_w.messages_queued, e.messages_queued);
          if (out_w.overflows != e.overflows)
            report("overflows", out_w.overflows, e.overflows);
          if (out_w.bytes_seen != e.bytes_seen)
            report("bytes_seen", out_w.bytes_seen, e.bytes_seen);
          if (out_w.queue_fill != e.queue_fill)
            report("queue_fill", out_w.queue_fill, e.queue_fill);
        end
      end
      if (rx_idle_left > 0) begin
        rx_idle_left <= rx_idle_left - 1;
        pop_q        <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        rx_idle_left <= $urandom_range(1, 17) - 1;
        pop_q        <= 1'b0;
      end else begin
        pop_q <= !rx_hold;
      end
    end
  end

  int rx_gap;
  always @(posedge clk) begin
    if (rx_hold) begin
      if (rx_gap == 0) rx_hold <= 1'b0;
      else rx_gap <= rx_gap - 1;
    end
  end

  task automatic drain_results();
    push_q <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic send_message(input int unsigned len);
    send_item(CMD_ADDR_MATCH, 8'($urandom));
    for (int i = 0; i < len; i++) send_item(CMD_RX_BYTE, 8'($urandom));
    send_item(CMD_STOP, 8'($urandom));
  endtask

  task automatic test_directed();
    send_item(CMD_POP, 8'h00);
    send_item(CMD_STOP, 8'hff);
    send_item(CMD_ADDR_MATCH, 8'h00);
    send_item(CMD_RX_BYTE, 8'h00);
    send_item(CMD_RX_BYTE, 8'hff);
    send_item(CMD_RX_BYTE, 8'h5a);
    send_item(CMD_STOP, 8'h00);
    send_item(CMD_POP, 8'hff);
    send_item(CMD_POP, 8'h00);
    send_item(CMD_RX_BYTE, 8'ha5);
    send_item(CMD_BUS_ERROR, 8'h00);
    send_item(CMD_STOP, 8'h00);
    send_item(3'd5, 8'hff);
    send_item(3'd6, 8'h00);
    send_item(3'd7, 8'h80);
    send_item(CMD_ADDR_MATCH, 8'hff);
    drain_results();
  endtask

  // overflow the buffer once, fill the queue until a stop is refused, then empty it
  task automatic test_queue_full();
    send_message(BufBytes + 3);
    for (int i = 0; i < 6; i++) send_message(BufBytes);
    send_message(BufBytes - 6);
    send_item(CMD_STOP, 8'h00);
    for (int i = 0; i < 8; i++) send_item(CMD_POP, 8'h00);
    send_item(CMD_STOP, 8'h00);
    send_item(CMD_POP, 8'h00);
    send_item(CMD_BUS_ERROR, 8'h00);
    drain_results();
  endtask

  task automatic test_receiver_hold();
    rx_gap  = 400;
    rx_hold = 1'b1;
    for (int i = 0; i < 12; i++) send_item(CMD_RX_BYTE, 8'($urandom));
    send_item(CMD_STOP, 8'h00);
    send_item(CMD_POP, 8'h00);
    drain_results();
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, BufBytes + 2)
                                           : $urandom_range(1, 6);
        send_message(len);
        sent += len + 2;
        if ($urandom_range(0, 1)) begin
          send_item(CMD_POP, 8'($urandom));
          sent++;
        end
      end else begin
        send_item(3'($urandom_range(0, 7)), 8'($urandom));
        sent++;
      end
    end
    for (int i = 0; i < 12; i++) send_item(CMD_POP, 8'h00);
    drain_results();
  endtask

  initial begin
    rst_n      = 1'b0;
    push_q     = 1'b0;
    in_q       = '0;
    errors     = 0;
    cycles     = 0;
    msg_fill   = 0;
    n_match    = '0;
    n_msg      = '0;
    n_ovf      = '0;
    n_bytes    = '0;
    rx_hold    = 1'b0;
    rx_gap     = 0;
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_queue_full();
    test_receiver_hold();
    test_random(30);
    rx_idle_on = 1'b0;
    tx_idle_on = 1'b0;
    test_random(20);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/i2csmq_pkg.sv
rtl/i2csmq_front.sv
rtl/i2csmq_back.sv
rtl/i2c_slave_message_queue_core.sv
verif/i2c_slave_message_queue_core_tb.sv
